### hdl/p2c_pkg.sv
// ----------------------------------------------------------------------------
// p2c_pkg
// shared constants, character codes, status codes and the sine table for the
// polar to cartesian line parser
// ----------------------------------------------------------------------------
package p2c_pkg;

    // widths
    localparam int DIST_WIDTH     = 16;
    localparam int TRIG_FRAC_BITS = 16;
    localparam int TABLE_BITS     = 30;
    localparam int ANGLE_W        = 9;
    localparam int OUT_W          = 16;

    // largest distance magnitude kept
    localparam logic [DIST_WIDTH-1:0] DIST_LIMIT = {1'b0, {(DIST_WIDTH-1){1'b1}}};

    // recurrence seeds, units of 2^-30
    localparam longint SIN1_Q30 = 64'sd18739379;
    localparam longint COS1_Q30 = 64'sd1073578288;

    // character codes
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_ANGLE   = 2'd1;
    localparam logic [1:0] ST_NO_DIST    = 2'd2;
    localparam logic [1:0] ST_DIST_OVFL  = 2'd3;

    typedef logic [TRIG_FRAC_BITS:0] trig_entry_t;
    typedef trig_entry_t trig_tab_t [0:90];

    // sin(k degrees), k = 0..90, built by angle addition at elaboration
    function automatic trig_tab_t build_trig_tab();
        trig_tab_t tab;
        longint    s;
        longint    c;
        longint    ns;
        longint    nc;
        longint    v;
        longint    one;
        longint    half;
        int        sh;
        one  = longint'(1) << TABLE_BITS;
        half = longint'(1) << (TABLE_BITS - 1);
        sh   = TABLE_BITS - TRIG_FRAC_BITS;
        s    = 0;
        c    = one;
        for (int k = 0; k <= 90; k++) begin
            v = s;
            if (sh > 0) begin
                v = (v + (longint'(1) << (sh - 1))) >>> sh;
            end
            tab[k] = trig_entry_t'(v);
            ns = (s * COS1_Q30 + c * SIN1_Q30 + half) >>> TABLE_BITS;
            nc = c * COS1_Q30 - s * SIN1_Q30 + half;
            nc = (nc < 0) ? longint'(0) : (nc >>> TABLE_BITS);
            if (ns > one) begin
                ns = one;
            end
            if (nc > one) begin
                nc = one;
            end
            s = ns;
            c = nc;
        end
        return tab;
    endfunction

    localparam trig_tab_t TRIG_TAB = build_trig_tab();

endpackage

### hdl/ascii_polar_to_cartesian_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_polar_to_cartesian_parser_core
// text line parser for "angle,distance" that emits one cartesian point per line
// ----------------------------------------------------------------------------
// The core takes one received character per word on the s_ channel and emits
// one point word on the m_ channel for every newline that closes a line holding
// a comma. Both fields are read like strtol (leading blanks, optional sign,
// decimal digits, the rest of the field ignored); the angle is kept modulo 360
// and the distance is limited to 2^(DIST_WIDTH-1)-1 with an overflow flag. A
// character is accepted every cycle: it lands in an input register, the parse
// update moves it into the line state registers, and the sine table lookup and
// multiply run from those into the result register, which a closing newline
// loads from the input register. The only stall is a point waiting in a full result
// register while m_ready is low; then a newline that would emit holds in the
// input register and s_ready drops. Status 0 is ok, 1 no angle digits, 2 no
// distance digits, 3 distance overflow; on any non-zero status x and y are 0.
// Empty lines and lines without a comma emit nothing.
// ----------------------------------------------------------------------------
module ascii_polar_to_cartesian_parser_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    // character input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    // point output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [15:0]       m_point_x,
    output logic signed [15:0]       m_point_y,
    output logic [1:0]               m_status
);

    localparam int DW   = p2c_pkg::DIST_WIDTH;
    localparam int TF   = p2c_pkg::TRIG_FRAC_BITS;
    localparam int AW   = p2c_pkg::ANGLE_W;
    localparam int PW   = DW + TF + 1;   // product width

    // line parse phases
    typedef enum logic [2:0] {
        PH_A_WS   = 3'd0,
        PH_A_NUM  = 3'd1,
        PH_A_REST = 3'd2,
        PH_R_WS   = 3'd3,
        PH_R_NUM  = 3'd4,
        PH_R_REST = 3'd5
    } phase_t;

    // input register
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;

    // line state
    phase_t          phase_reg,      phase_next;
    logic [AW-1:0]   angle_reg,      angle_next;
    logic            angle_neg_reg,  angle_neg_next;
    logic            angle_dig_reg,  angle_dig_next;
    logic [DW-1:0]   range_reg,      range_next;
    logic            range_neg_reg,  range_neg_next;
    logic            range_dig_reg,  range_dig_next;
    logic            range_ovf_reg,  range_ovf_next;

    // result register
    logic            out_valid_reg;
    logic [15:0]     out_x_reg,      out_x_next;
    logic [15:0]     out_y_reg,      out_y_next;
    logic [1:0]      out_st_reg,     out_st_next;

    // handshake and flow
    logic            is_newline;
    logic            emits;          // word in input register makes a point
    logic            out_free;       // result register can take a point
    logic            in_move;        // input register word is consumed now
    logic            load_out;

    // character classes
    logic            is_digit;
    logic            is_space;
    logic            is_sign;
    logic [3:0]      digit_val;

    // angle digit step: (angle*10 + d) mod 360, input below 3600
    logic [11:0]     angle_acc;
    logic [AW-1:0]   angle_mod;

    // distance digit step
    logic [DW+3:0]   range_acc;

    // quadrant split
    logic [1:0]      quad;
    logic [6:0]      quad_rem;
    logic [6:0]      quad_comp;
    p2c_pkg::trig_entry_t tab_r;
    p2c_pkg::trig_entry_t tab_c;
    p2c_pkg::trig_entry_t t_sin;
    p2c_pkg::trig_entry_t t_cos;
    logic            sin_neg;
    logic            cos_neg;
    logic [PW-1:0]   prod_x;
    logic [PW-1:0]   prod_y;

    // scale the product down and saturate to 16 bits with the sign applied
    function automatic logic [15:0] scale_sat(input logic [PW-1:0] prod, input logic neg);
        logic [32:0] v;
        logic [16:0] m;
        v = 33'(prod >> TF);
        if (neg) begin
            m = (v > 33'd32768) ? 17'd32768 : v[16:0];
            return 16'(17'd0 - m);
        end
        return (v > 33'd32767) ? 16'd32767 : v[15:0];
    endfunction

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    assign is_newline = (in_byte_reg == p2c_pkg::CHAR_NL);
    // any phase past the comma, unused codes included
    assign emits      = is_newline && (phase_reg != PH_A_WS) && (phase_reg != PH_A_NUM)
                        && (phase_reg != PH_A_REST);
    assign out_free   = !out_valid_reg || m_ready;
    assign in_move    = in_valid_reg && (!emits || out_free);
    assign load_out   = in_move && emits;
    assign s_ready    = !in_valid_reg || in_move;

    assign m_valid    = out_valid_reg;
    assign m_point_x  = out_x_reg;
    assign m_point_y  = out_y_reg;
    assign m_status   = out_st_reg;

    // ------------------------------------------------------------------
    // character classification
    // ------------------------------------------------------------------
    assign is_digit  = (in_byte_reg >= p2c_pkg::CHAR_ZERO) && (in_byte_reg <= p2c_pkg::CHAR_NINE);
    assign digit_val = 4'(in_byte_reg - p2c_pkg::CHAR_ZERO);
    assign is_sign   = (in_byte_reg == p2c_pkg::CHAR_PLUS) || (in_byte_reg == p2c_pkg::CHAR_MINUS);
    assign is_space  = (in_byte_reg == p2c_pkg::CHAR_SPACE) || (in_byte_reg == p2c_pkg::CHAR_TAB)
                    || (in_byte_reg == p2c_pkg::CHAR_VT) || (in_byte_reg == p2c_pkg::CHAR_FF)
                    || (in_byte_reg == p2c_pkg::CHAR_CR);

    // angle accumulate, reduced by the largest multiple of 360 that fits
    assign angle_acc = 12'(angle_reg) * 12'd10 + 12'(digit_val);

    always_comb begin
        logic [11:0] rem;
        rem = angle_acc;
        for (int k = 1; k <= 9; k++) begin
            if (angle_acc >= 12'(360 * k)) begin
                rem = angle_acc - 12'(360 * k);
            end
        end
        angle_mod = rem[AW-1:0];
    end

    // distance accumulate, magnitude kept at or under its limit
    assign range_acc = (DW+4)'(range_reg) * (DW+4)'(10) + (DW+4)'(digit_val);

    // ------------------------------------------------------------------
    // parse update
    // ------------------------------------------------------------------
    always_comb begin
        phase_next     = phase_reg;
        angle_next     = angle_reg;
        angle_neg_next = angle_neg_reg;
        angle_dig_next = angle_dig_reg;
        range_next     = range_reg;
        range_neg_next = range_neg_reg;
        range_dig_next = range_dig_reg;
        range_ovf_next = range_ovf_reg;

        if (is_newline) begin
            // line done, start afresh
            phase_next     = PH_A_WS;
            angle_next     = '0;
            angle_neg_next = 1'b0;
            angle_dig_next = 1'b0;
            range_next     = '0;
            range_neg_next = 1'b0;
            range_dig_next = 1'b0;
            range_ovf_next = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_A_WS: begin
                    if (in_byte_reg == p2c_pkg::CHAR_COMMA) begin
                        phase_next = PH_R_WS;
                    end else if (is_space) begin
                        phase_next = PH_A_WS;
                    end else if (is_sign) begin
                        angle_neg_next = (in_byte_reg == p2c_pkg::CHAR_MINUS);
                        phase_next     = PH_A_NUM;
                    end else if (is_digit) begin
                        angle_next     = AW'(digit_val);
                        angle_dig_next = 1'b1;
                        phase_next     = PH_A_NUM;
                    end else begin
                        phase_next = PH_A_REST;
                    end
                end
                PH_A_NUM: begin
                    if (is_digit) begin
                        angle_next     = angle_mod;
                        angle_dig_next = 1'b1;
                    end else if (in_byte_reg == p2c_pkg::CHAR_COMMA) begin
                        phase_next = PH_R_WS;
                    end else begin
                        phase_next = PH_A_REST;
                    end
                end
                PH_A_REST: begin
                    if (in_byte_reg == p2c_pkg::CHAR_COMMA) begin
                        phase_next = PH_R_WS;
                    end
                end
                PH_R_WS: begin
                    if (is_space) begin
                        phase_next = PH_R_WS;
                    end else if (is_sign) begin
                        range_neg_next = (in_byte_reg == p2c_pkg::CHAR_MINUS);
                        phase_next     = PH_R_NUM;
                    end else if (is_digit) begin
                        range_next     = DW'(digit_val);
                        range_dig_next = 1'b1;
                        phase_next     = PH_R_NUM;
                    end else begin
                        phase_next = PH_R_REST;
                    end
                end
                PH_R_NUM: begin
                    if (is_digit) begin
                        range_dig_next = 1'b1;
                        if (range_acc > (DW+4)'(p2c_pkg::DIST_LIMIT)) begin
                            range_next     = p2c_pkg::DIST_LIMIT;
                            range_ovf_next = 1'b1;
                        end else begin
                            range_next = range_acc[DW-1:0];
                        end
                    end else begin
                        phase_next = PH_R_REST;
                    end
                end
                default: begin
                    // rest of the distance is ignored
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // point computation
    // ------------------------------------------------------------------
    always_comb begin
        if (angle_reg >= AW'(270)) begin
            quad     = 2'd3;
            quad_rem = 7'(angle_reg - AW'(270));
        end else if (angle_reg >= AW'(180)) begin
            quad     = 2'd2;
            quad_rem = 7'(angle_reg - AW'(180));
        end else if (angle_reg >= AW'(90)) begin
            quad     = 2'd1;
            quad_rem = 7'(angle_reg - AW'(90));
        end else begin
            quad     = 2'd0;
            quad_rem = 7'(angle_reg);
        end
    end

    assign quad_comp = 7'd90 - quad_rem;
    assign tab_r     = p2c_pkg::TRIG_TAB[quad_rem];
    assign tab_c     = p2c_pkg::TRIG_TAB[quad_comp];
    // odd quadrants swap sine and cosine
    assign t_sin     = quad[0] ? tab_c : tab_r;
    assign t_cos     = quad[0] ? tab_r : tab_c;
    assign sin_neg   = quad[1];
    assign cos_neg   = quad[1] ^ quad[0];

    assign prod_x    = PW'(range_reg) * PW'(t_cos);
    assign prod_y    = PW'(range_reg) * PW'(t_sin);

    always_comb begin
        out_x_next = '0;
        out_y_next = '0;
        priority if (!angle_dig_reg) begin
            out_st_next = p2c_pkg::ST_NO_ANGLE;
        end else if (!range_dig_reg) begin
            out_st_next = p2c_pkg::ST_NO_DIST;
        end else if (range_ovf_reg) begin
            out_st_next = p2c_pkg::ST_DIST_OVFL;
        end else begin
            out_st_next = p2c_pkg::ST_OK;
            out_x_next  = scale_sat(prod_x, cos_neg ^ range_neg_reg);
            // negative angle mirrors y
            out_y_next  = scale_sat(prod_y, sin_neg ^ range_neg_reg ^ angle_neg_reg);
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_A_WS;
            angle_reg     <= '0;
            angle_neg_reg <= 1'b0;
            angle_dig_reg <= 1'b0;
            range_reg     <= '0;
            range_neg_reg <= 1'b0;
            range_dig_reg <= 1'b0;
            range_ovf_reg <= 1'b0;
        end else begin
            // input register
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (in_move) begin
                in_valid_reg <= 1'b0;
            end

            // line state advances with each consumed word
            if (in_move) begin
                phase_reg     <= phase_next;
                angle_reg     <= angle_next;
                angle_neg_reg <= angle_neg_next;
                angle_dig_reg <= angle_dig_next;
                range_reg     <= range_next;
                range_neg_reg <= range_neg_next;
                range_dig_reg <= range_dig_next;
                range_ovf_reg <= range_ovf_next;
            end

            // result register
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (load_out) begin
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            out_st_reg <= out_st_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_angle_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        angle_reg < AW'(360))
        else $error("angle residue not reduced");

    a_range_limited: assert property (@(posedge aclk) disable iff (!aresetn)
        range_reg <= p2c_pkg::DIST_LIMIT)
        else $error("distance magnitude above limit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !load_out)
        else $error("unread point overwritten");

    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_move && is_newline) |=> (phase_reg == PH_A_WS) && !angle_dig_reg && !range_dig_reg)
        else $error("line state not cleared after newline");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_st_reg != p2c_pkg::ST_OK))
            |-> (out_x_reg == '0) && (out_y_reg == '0))
        else $error("error point carries coordinates");

endmodule
